>>> rtl/core/sorted_key_table_top_macros.svh
// sorted_key_table_top_macros.svh: assertion macros for the sorted key table
// depends on nothing; included by sorted_key_table_top
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SKT_CHECK_NOW(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("sorted key table check failed");

// condition holds in the cycle after the trigger
`define SKT_CHECK_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("sorted key table check failed");

`endif

>>> rtl/core/skt_pkg.sv
// skt_pkg: constants, codes and shared types of the sorted key table
// depends on nothing
`timescale 1ns / 1ps

package skt_pkg;

   localparam int CAPACITY = 256;
   localparam int KEY_W    = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 9;
   localparam int OP_W     = 2;
   localparam int ST_W     = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL = 2'd1;
   localparam logic [ST_W-1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             we;
      logic [IDX_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] position;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] entries_held;
   } result_type;

endpackage

>>> rtl/core/sorted_key_table_top.sv
// sorted_key_table_top: ascending key table with lookup, insert and remove
// a search step is one key ram read and then one compare, at most nine steps per search;
// insert and remove then move each shifted entry one slot over, and insert writes the key;
// one transaction at a time: a new request waits until the last result has left the
// sequencer; a stalled result holds it
// synchronous active-high reset empties the table
`timescale 1ns / 1ps
`include "sorted_key_table_top_macros.svh"

module sorted_key_table_top
   import skt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [KEY_W-1:0]  req_key,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [POS_W-1:0]  rsp_position,
   output logic [ST_W-1:0]   rsp_status,
   output logic [POS_W-1:0]  rsp_entries_held
);

   ram_req_type       ram_req;
   logic [KEY_W-1:0]  ram_rd_data;
   result_type        result;
   logic              busy;
   logic              done;
   logic              rsp_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic [ST_W-1:0]   status_ff, status_in;
   logic [POS_W-1:0]  held_ff, held_in;

   skt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .we      (ram_req.we),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   skt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_opcode  (req_opcode),
      .req_key     (req_key),
      .busy        (busy),
      .rsp_free    (rsp_free),
      .done        (done),
      .result      (result),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   assign req_stall = busy;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      position_in  = position_ff;
      status_in    = status_ff;
      held_in      = held_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         found_in     = result.found;
         position_in  = POS_W'(result.position);
         status_in    = result.status;
         held_in      = POS_W'(result.entries_held);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff    <= found_in;
      position_ff <= position_in;
      status_ff   <= status_in;
      held_ff     <= held_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_position     = position_ff;
   assign rsp_status       = status_ff;
   assign rsp_entries_held = held_ff;

   `SKT_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `SKT_CHECK_NOW(a_held_in_range, rsp_valid, rsp_entries_held <= POS_W'(CAPACITY))
   `SKT_CHECK_NOW(a_full_means_full, rsp_valid && rsp_status == ST_FULL,
      rsp_entries_held == POS_W'(CAPACITY))
   `SKT_CHECK_NOW(a_miss_not_found, rsp_valid && rsp_status == ST_MISS, !rsp_found)

endmodule

>>> rtl/core/skt_ram.sv
// skt_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/skt_seq.sv
// skt_seq: sequencer with key comparator for search, and entry shift and key write back
// depends on skt_pkg; drives the key ram through a ram_req_type struct
`timescale 1ns / 1ps

module skt_seq
   import skt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [KEY_W-1:0]  req_key,
   output logic              busy,
   input  logic              rsp_free,
   output logic              done,
   output result_type        result,
   output ram_req_type       ram_req,
   input  logic [KEY_W-1:0]  ram_rd_data
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PROBE = 8'b0000_0010,
      S_CMP   = 8'b0000_0100,
      S_PLAN  = 8'b0000_1000,
      S_SHIFT = 8'b0001_0000,
      S_DRAIN = 8'b0010_0000,
      S_PUT   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [ST_W-1:0]   status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  src_ff, src_in;
   logic [CNT_W-1:0]  moves_ff, moves_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  wa_ff, wa_in;

   logic [CNT_W:0]    mid_sum;
   logic [IDX_W-1:0]  mid;
   logic              is_insert;
   logic [CNT_W-1:0]  moves_calc;

   // hi_ff holds high + 1, so the window is lo_ff .. hi_ff - 1
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid       = mid_sum[IDX_W:1];
   assign is_insert = (op_ff == OP_INSERT);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      hit_in     = hit_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      count_in   = count_ff;
      src_in     = src_ff;
      moves_in   = moves_ff;
      pend_in    = 1'b0;
      wa_in      = wa_ff;
      moves_calc = '0;
      done       = 1'b0;

      ram_req.rd_addr = mid_ff;
      ram_req.we      = pend_ff;
      ram_req.wr_addr = wa_ff;
      ram_req.wr_data = ram_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               key_in    = req_key;
               lo_in     = '0;
               hi_in     = count_ff;
               status_in = ST_DONE;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in          = mid;
               ram_req.rd_addr = mid;
               state_in        = S_CMP;
            end else begin
               hit_in   = 1'b0;
               pos_in   = lo_ff;
               state_in = S_PLAN;
            end
         end
         S_CMP: begin
            if (ram_rd_data == key_ff) begin
               hit_in   = 1'b1;
               pos_in   = CNT_W'(mid_ff);
               state_in = S_PLAN;
            end else begin
               if (ram_rd_data < key_ff) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_in = CNT_W'(mid_ff);
               end
               state_in = S_PROBE;
            end
         end
         S_PLAN: begin
            state_in = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     moves_calc = count_ff - pos_ff;
                     moves_in   = moves_calc;
                     src_in     = IDX_W'(count_ff - CNT_W'(1));
                     count_in   = count_ff + CNT_W'(1);
                     state_in   = (moves_calc == '0) ? S_PUT : S_SHIFT;
                  end
               end
               OP_REMOVE: begin
                  if (!hit_ff) begin
                     status_in = ST_MISS;
                  end else begin
                     moves_calc = count_ff - pos_ff - CNT_W'(1);
                     moves_in   = moves_calc;
                     src_in     = IDX_W'(pos_ff + CNT_W'(1));
                     count_in   = count_ff - CNT_W'(1);
                     state_in   = (moves_calc == '0) ? S_DONE : S_SHIFT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            // read one entry per cycle, write it back one slot over next cycle
            ram_req.rd_addr = src_ff;
            pend_in         = 1'b1;
            wa_in           = is_insert ? (src_ff + IDX_W'(1)) : (src_ff - IDX_W'(1));
            src_in          = is_insert ? (src_ff - IDX_W'(1)) : (src_ff + IDX_W'(1));
            moves_in        = moves_ff - CNT_W'(1);
            if (moves_ff == CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = is_insert ? S_PUT : S_DONE;
         end
         S_PUT: begin
            ram_req.we      = 1'b1;
            ram_req.wr_addr = IDX_W'(pos_ff);
            ram_req.wr_data = key_ff;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      hit_ff    <= hit_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      src_ff    <= src_in;
      moves_ff  <= moves_in;
      wa_ff     <= wa_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign result.found        = hit_ff;
   assign result.position     = pos_ff;
   assign result.status       = status_ff;
   assign result.entries_held = count_ff;

endmodule

>>> tb/sv/tb.sv
// tb.sv: self-checking testbench for sorted_key_table_top, lookup, insert and remove
// transactions checked against a shadow copy of the ascending key table
// depends on skt_pkg and the sorted_key_table_top rtl
`timescale 1ns / 1ps

class key_table_scoreboard;
   logic [skt_pkg::KEY_W-1:0] shadow_keys [skt_pkg::CAPACITY];
   int                        shadow_count;
   skt_pkg::result_type       pending_results [$];
   int unsigned               mismatches, responses_checked;
   int unsigned               lookups, inserts, removes, refused, missed, hits;
   int                        peak_count;

   function new();
      shadow_count = 0;
      mismatches = 0;
      responses_checked = 0;
      lookups = 0;
      inserts = 0;
      removes = 0;
      refused = 0;
      missed = 0;
      hits = 0;
      peak_count = 0;
   endfunction

   function bit search_shadow(input logic [skt_pkg::KEY_W-1:0] key, output int pos);
      int lo, hi, mid;
      lo = 0;
      hi = shadow_count - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (shadow_keys[mid] == key) begin
            pos = mid;
            return 1'b1;
         end
         if (shadow_keys[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      pos = lo;
      return 1'b0;
   endfunction

   function void note_request(input logic [skt_pkg::OP_W-1:0] op,
                              input logic [skt_pkg::KEY_W-1:0] key);
      skt_pkg::result_type res;
      int pos;
      bit hit;
      hit = search_shadow(key, pos);
      res.status = skt_pkg::ST_DONE;
      if (hit) hits++;
      if (op == skt_pkg::OP_INSERT) begin
         inserts++;
         if (shadow_count >= skt_pkg::CAPACITY) begin
            res.status = skt_pkg::ST_FULL;
            refused++;
         end else begin
            for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[pos] = key;
            shadow_count++;
         end
      end else if (op == skt_pkg::OP_REMOVE) begin
         removes++;
         if (!hit) begin
            res.status = skt_pkg::ST_MISS;
            missed++;
         end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_count--;
         end
      end else begin
         lookups++;
      end
      if (shadow_count > peak_count) peak_count = shadow_count;
      res.found = hit;
      res.position = pos[skt_pkg::CNT_W-1:0];
      res.entries_held = shadow_count[skt_pkg::CNT_W-1:0];
      pending_results.push_back(res);
   endfunction

   function void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   function void check_response(input logic found,
                                input logic [skt_pkg::POS_W-1:0] position,
                                input logic [skt_pkg::ST_W-1:0] status,
                                input logic [skt_pkg::POS_W-1:0] held);
      skt_pkg::result_type want;
      if (pending_results.size() == 0) begin
         flag($sformatf("response with no transaction outstanding: found %0d position %0d status %0d held %0d",
                        found, position, status, held));
         return;
      end
      want = pending_results.pop_front();
      responses_checked++;
      if (found !== want.found || position !== want.position ||
          status !== want.status || held !== want.entries_held)
         flag($sformatf("response %0d: expected found %0d position %0d status %0d held %0d, got found %0d position %0d status %0d held %0d",
                        responses_checked, want.found, want.position, want.status,
                        want.entries_held, found, position, status, held));
   endfunction
endclass

module tb;
   import skt_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 320;
   localparam int RANDOM_ITEMS = 1250;
   localparam int PHASE_ITEMS  = 417;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_opcode = OP_LOOKUP;
   logic [KEY_W-1:0]  req_key = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [POS_W-1:0]  rsp_position;
   logic [ST_W-1:0]   rsp_status;
   logic [POS_W-1:0]  rsp_entries_held;

   key_table_scoreboard board = new();
   int  send_idle_pct = 17;
   int  recv_idle_pct = 61;
   bit  filling = 1'b1;
   int  cycle_count = 0;

   sorted_key_table_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position),
      .rsp_status(rsp_status),
      .rsp_entries_held(rsp_entries_held)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_response(rsp_found, rsp_position, rsp_status, rsp_entries_held);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, board.pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   // lowers valid and holds off until every response is back
   task automatic wait_for_empty();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending_results.size() != 0);
   endtask

   task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      if (send_idle_pct != 0 && $urandom_range(99) < 2) wait_for_empty();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_key <= key;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(op, key);
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key(input bit want_present);
      int r;
      r = $urandom_range(99);
      if (want_present && board.shadow_count > 0 && r < 70)
         return board.shadow_keys[$urandom_range(board.shadow_count - 1)];
      r = $urandom_range(99);
      if (r < 30) return KEY_W'($urandom_range(15));
      if (r < 45) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      if (r < 60 && board.shadow_count > 0) begin
         if ($urandom_range(1) != 0)
            return board.shadow_keys[$urandom_range(board.shadow_count - 1)] + 1'b1;
         return board.shadow_keys[$urandom_range(board.shadow_count - 1)] - 1'b1;
      end
      return $urandom();
   endfunction

   // alternates between growing the table to full and draining it
   task automatic run_random(input int count);
      int r;
      logic [OP_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         if (filling && board.shadow_count == CAPACITY && $urandom_range(3) == 0)
            filling = 1'b0;
         else if (!filling && board.shadow_count < 8 && $urandom_range(3) == 0)
            filling = 1'b1;
         r = $urandom_range(99);
         if (filling)
            op = (r < 80) ? OP_INSERT : (r < 90) ? OP_REMOVE : (r < 97) ? OP_LOOKUP : OP_SPARE;
         else
            op = (r < 10) ? OP_INSERT : (r < 85) ? OP_REMOVE : (r < 96) ? OP_LOOKUP : OP_SPARE;
         send(op, pick_key(op != OP_INSERT));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, extremes, duplicates at both ends and in the middle
      send(OP_LOOKUP, 32'h0000_0000);
      send(OP_REMOVE, 32'h0000_0005);
      send(OP_SPARE,  32'hFFFF_FFFF);
      send(OP_INSERT, 32'h0000_0000);
      send(OP_INSERT, 32'hFFFF_FFFF);
      send(OP_INSERT, 32'h8000_0000);
      send(OP_INSERT, 32'h8000_0000);
      send(OP_INSERT, 32'h0000_0000);
      send(OP_INSERT, 32'hFFFF_FFFF);
      send(OP_LOOKUP, 32'h8000_0000);
      send(OP_LOOKUP, 32'h7FFF_FFFF);
      send(OP_LOOKUP, 32'hFFFF_FFFF);
      send(OP_LOOKUP, 32'h0000_0000);
      send(OP_SPARE,  32'h8000_0000);
      send(OP_REMOVE, 32'h7FFF_FFFF);
      send(OP_REMOVE, 32'h8000_0000);
      send(OP_REMOVE, 32'h0000_0000);
      send(OP_REMOVE, 32'hFFFF_FFFF);
      send(OP_LOOKUP, 32'h5555_5555);
      send(OP_INSERT, 32'hAAAA_AAAA);
      send(OP_INSERT, 32'h5555_5555);
      send(OP_REMOVE, 32'hAAAA_AAAA);
      send(OP_REMOVE, 32'h5555_5555);

      run_random(PHASE_ITEMS);
      wait_for_empty();
      send_idle_pct = 61;
      recv_idle_pct = 17;
      run_random(PHASE_ITEMS);
      wait_for_empty();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_ITEMS - 2 * PHASE_ITEMS);
      wait_for_empty();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d transactions: %0d lookups, %0d inserts (%0d refused on a full table), %0d removes (%0d of absent keys)",
               board.lookups + board.inserts + board.removes, board.lookups, board.inserts,
               board.refused, board.removes, board.missed);
      $display("%0d searches hit, table peaked at %0d keys, %0d responses checked, %0d mismatches",
               board.hits, board.peak_count, board.responses_checked, board.mismatches);
      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
